@@ src/button_event_engine_macros.svh @@
// Assertion helpers shared by the button event engine RTL.
`ifndef BUTTON_EVENT_ENGINE_MACROS_SVH
`define BUTTON_EVENT_ENGINE_MACROS_SVH

`ifndef SYNTHESIS
// Property checked on the rising clock edge, off while reset is asserted.
`define BEE_ASSERT(lbl, clk, rstn, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (prop)) else $error(msg);
// Condition that must never be true on a clock edge.
`define BEE_ASSERT_NEVER(lbl, clk, rstn, cond, msg) \
  `BEE_ASSERT(lbl, clk, rstn, !(cond), msg)
`else
`define BEE_ASSERT(lbl, clk, rstn, prop, msg)
`define BEE_ASSERT_NEVER(lbl, clk, rstn, cond, msg)
`endif

`endif

@@ src/bee_pkg.sv @@
`timescale 1ns / 1ps

package bee_pkg;

  // Fixed sizes
  localparam int unsigned HW_BUTTONS           = 4;
  localparam int unsigned DEF_FIFO_DEPTH       = 16;
  localparam int unsigned DEF_LOGICAL_BUTTONS  = 6;
  localparam int unsigned MACH_W               = 5;
  localparam int unsigned TICK_W               = 16;
  localparam int unsigned FILTER_W             = 8;
  localparam int unsigned KEYS_W               = 4;
  localparam int unsigned EVENT_W              = 6;
  localparam int unsigned CFG_IDX_W            = 3;
  localparam int unsigned CFG_DATA_W           = 16;
  localparam int unsigned IN_TDATA_W           = 8;
  localparam int unsigned OUT_TDATA_W          = 24;
  localparam int unsigned LEVEL_W              = 5;
  localparam int unsigned CNT_W                = 3;

  // Register reset values
  localparam logic [HW_BUTTONS-1:0] RST_ACTIVE_HIGH = 4'd8;
  localparam logic [FILTER_W-1:0]   RST_FILTER      = 8'd2;
  localparam logic [TICK_W-1:0]     RST_LONG_PRESS  = 16'd100;
  localparam logic [TICK_W-1:0]     RST_HOLD        = 16'd5;
  localparam logic [KEYS_W-1:0]     RST_COMBO_ONE   = 4'd3;
  localparam logic [KEYS_W-1:0]     RST_COMBO_TWO   = 4'd11;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_ACTIVE_HIGH = 3'd0,
    REG_FILTER      = 3'd1,
    REG_LONG_PRESS  = 3'd2,
    REG_HOLD        = 3'd3,
    REG_COMBO_ONE   = 3'd4,
    REG_COMBO_TWO   = 3'd5
  } cfg_reg_e;

  typedef enum logic {
    KIND_TICK = 1'b0,
    KIND_READ = 1'b1
  } kind_e;

  typedef enum logic [1:0] {
    ACT_UP   = 2'd0,
    ACT_DOWN = 2'd1,
    ACT_BRK  = 2'd2
  } action_e;

  typedef enum logic [2:0] {
    EV_DOWN   = 3'd0,
    EV_UP     = 3'd1,
    EV_LSTART = 3'd2,
    EV_LHOLD  = 3'd3,
    EV_LUP    = 3'd4
  } event_code_e;

  // Press machine state, kept one-hot in the state memory
  typedef enum logic [3:0] {
    PS_IDLE = 4'b0001,
    PS_DOWN = 4'b0010,
    PS_LONG = 4'b0100,
    PS_BRK  = 4'b1000
  } press_state_e;

  typedef struct packed {
    press_state_e            st;
    logic [TICK_W-1:0]       tick;
  } press_entry_t;

  localparam int unsigned PRESS_ENTRY_W = $bits(press_entry_t);
  localparam press_entry_t PRESS_RESET  = '{st: PS_IDLE, tick: '0};

  typedef struct packed {
    logic         push;
    event_code_e  code;
    press_entry_t entry;
  } press_res_t;

  typedef struct packed {
    logic               push;
    logic [EVENT_W-1:0] data;
    logic               pop;
  } fifo_req_t;

endpackage

@@ src/bee_ram.sv @@
`timescale 1ns / 1ps

module bee_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16,
  parameter int unsigned AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // One write port, one registered read port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

@@ src/bee_debounce.sv @@
`timescale 1ns / 1ps

module bee_debounce (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             tick_i,
  input  logic [bee_pkg::HW_BUTTONS-1:0]   raw_i,
  input  logic [bee_pkg::HW_BUTTONS-1:0]   active_high_i,
  input  logic [bee_pkg::FILTER_W-1:0]     filter_i,
  output logic [bee_pkg::HW_BUTTONS-1:0]   deb_o
);

  import bee_pkg::*;

  logic [HW_BUTTONS-1:0] deb_q, deb_d;
  logic [FILTER_W-1:0]   cnt_q [HW_BUTTONS];
  logic [FILTER_W-1:0]   cnt_d [HW_BUTTONS];

  // Per-button filter lanes: count ticks that disagree, flip at threshold
  always_comb begin
    logic             active;
    logic [FILTER_W-1:0] inc;
    deb_d = deb_q;
    for (int i = 0; i < HW_BUTTONS; i++) begin
      active   = (raw_i[i] == active_high_i[i]);
      inc      = cnt_q[i] + FILTER_W'(1);
      cnt_d[i] = cnt_q[i];
      if (tick_i) begin
        if (deb_q[i] != active) begin
          if (inc >= filter_i) begin
            deb_d[i] = ~deb_q[i];
            cnt_d[i] = '0;
          end else begin
            cnt_d[i] = inc;
          end
        end else begin
          cnt_d[i] = '0;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      deb_q <= '0;
      for (int i = 0; i < HW_BUTTONS; i++) begin
        cnt_q[i] <= '0;
      end
    end else begin
      deb_q <= deb_d;
      for (int i = 0; i < HW_BUTTONS; i++) begin
        cnt_q[i] <= cnt_d[i];
      end
    end
  end

  assign deb_o = deb_q;

endmodule

@@ src/bee_press_step.sv @@
`timescale 1ns / 1ps

module bee_press_step (
  input  bee_pkg::press_entry_t              entry_i,
  input  logic [bee_pkg::MACH_W-1:0]         mach_i,
  input  logic [bee_pkg::HW_BUTTONS-1:0]     deb_i,
  input  logic [bee_pkg::KEYS_W-1:0]         combo_one_i,
  input  logic [bee_pkg::KEYS_W-1:0]         combo_two_i,
  input  logic [bee_pkg::TICK_W-1:0]         long_press_i,
  input  logic [bee_pkg::TICK_W-1:0]         hold_i,
  output bee_pkg::press_res_t                res_o
);

  import bee_pkg::*;

  localparam logic [HW_BUTTONS-1:0] ONE = HW_BUTTONS'(1);

  action_e           act;
  logic [TICK_W-1:0] tick_inc;

  // Action seen by this machine: up, down or broken by another key
  always_comb begin
    logic [HW_BUTTONS-1:0] own;
    logic [HW_BUTTONS-1:0] lead;
    logic [HW_BUTTONS-1:0] second;
    logic [KEYS_W-1:0]     keys;
    logic                  combo;
    own    = '0;
    keys   = combo_one_i;
    combo  = 1'b0;
    act    = ACT_UP;
    if (mach_i < MACH_W'(HW_BUTTONS)) begin
      own = ONE << mach_i;
      if (|(deb_i & ~own)) begin
        act = ACT_BRK;
      end else if (|(deb_i & own)) begin
        act = ACT_DOWN;
      end
    end else if (mach_i == MACH_W'(HW_BUTTONS)) begin
      combo = 1'b1;
    end else if (mach_i == MACH_W'(HW_BUTTONS + 1)) begin
      keys  = combo_two_i;
      combo = 1'b1;
    end
    // two-bit keys always address a hardware button
    lead   = ONE << keys[1:0];
    second = ONE << keys[3:2];
    if (combo) begin
      if (|(deb_i & ~(lead | second))) begin
        act = ACT_BRK;
      end else if (!(|(deb_i & lead))) begin
        act = ACT_BRK;
      end else if (|(deb_i & second)) begin
        act = ACT_DOWN;
      end else begin
        act = ACT_UP;
      end
    end
  end

  assign tick_inc = entry_i.tick + TICK_W'(1);

  // Press state transition and event
  always_comb begin
    res_o.push  = 1'b0;
    res_o.code  = EV_DOWN;
    res_o.entry = entry_i;
    unique case (entry_i.st)
      PS_IDLE: begin
        if (act == ACT_DOWN) begin
          res_o.push        = 1'b1;
          res_o.code        = EV_DOWN;
          res_o.entry.tick  = '0;
          res_o.entry.st    = PS_DOWN;
        end
      end
      PS_DOWN: begin
        if (act == ACT_BRK) begin
          res_o.entry.st = PS_BRK;
        end else if (act == ACT_DOWN) begin
          res_o.entry.tick = tick_inc;
          if (tick_inc >= long_press_i) begin
            res_o.push       = 1'b1;
            res_o.code       = EV_LSTART;
            res_o.entry.tick = '0;
            res_o.entry.st   = PS_LONG;
          end
        end else begin
          res_o.push     = 1'b1;
          res_o.code     = EV_UP;
          res_o.entry.st = PS_IDLE;
        end
      end
      PS_LONG: begin
        if (act == ACT_BRK) begin
          res_o.entry.st = PS_BRK;
        end else if (act == ACT_DOWN) begin
          res_o.entry.tick = tick_inc;
          if (tick_inc >= hold_i) begin
            res_o.push       = 1'b1;
            res_o.code       = EV_LHOLD;
            res_o.entry.tick = '0;
          end
        end else begin
          res_o.push     = 1'b1;
          res_o.code     = EV_LUP;
          res_o.entry.st = PS_IDLE;
        end
      end
      PS_BRK: begin
        if (act == ACT_UP) begin
          res_o.entry.st = PS_IDLE;
        end
      end
      default: begin
        res_o.entry = PRESS_RESET;
      end
    endcase
  end

endmodule

@@ src/bee_event_fifo.sv @@
`timescale 1ns / 1ps
`include "button_event_engine_macros.svh"

module bee_event_fifo #(
  parameter int unsigned DEPTH = bee_pkg::DEF_FIFO_DEPTH
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  bee_pkg::fifo_req_t            req_i,
  output logic [bee_pkg::EVENT_W-1:0]   rd_data_o,
  output logic                          empty_o,
  output logic                          full_o,
  output logic [$clog2(DEPTH):0]        level_o
);

  import bee_pkg::*;

  localparam int unsigned AW  = $clog2(DEPTH);
  localparam int unsigned PW  = AW + 1;
  localparam int unsigned MOD = 2 * DEPTH;

  logic [PW-1:0] wr_q, wr_d, rd_q, rd_d;
  logic [PW-1:0] used;
  logic [PW:0]   used_sum;
  logic [PW-1:0] wr_fold, rd_fold;
  logic [AW-1:0] wr_idx, rd_idx;

  // Pointers run modulo twice the depth; fill level from their distance
  assign used_sum = {1'b0, wr_q} + (PW + 1)'(MOD) - {1'b0, rd_q};
  assign used     = (wr_q >= rd_q) ? (wr_q - rd_q) : used_sum[PW-1:0];
  assign empty_o  = (used == '0);
  assign full_o   = (used >= PW'(DEPTH));
  assign level_o  = used;

  // Storage slot of each pointer
  assign wr_fold = (wr_q >= PW'(DEPTH)) ? (wr_q - PW'(DEPTH)) : wr_q;
  assign rd_fold = (rd_q >= PW'(DEPTH)) ? (rd_q - PW'(DEPTH)) : rd_q;
  assign wr_idx  = wr_fold[AW-1:0];
  assign rd_idx  = rd_fold[AW-1:0];

  always_comb begin
    wr_d = wr_q;
    rd_d = rd_q;
    if (req_i.push) begin
      wr_d = (wr_q == PW'(MOD - 1)) ? '0 : wr_q + PW'(1);
    end
    if (req_i.pop) begin
      rd_d = (rd_q == PW'(MOD - 1)) ? '0 : rd_q + PW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q <= '0;
      rd_q <= '0;
    end else begin
      wr_q <= wr_d;
      rd_q <= rd_d;
    end
  end

  bee_ram #(
    .WIDTH (EVENT_W),
    .DEPTH (DEPTH),
    .AW    (AW)
  ) u_store (
    .clk_i   (clk_i),
    .we_i    (req_i.push),
    .waddr_i (wr_idx),
    .wdata_i (req_i.data),
    .re_i    (req_i.pop),
    .raddr_i (rd_idx),
    .rdata_o (rd_data_o)
  );

  `BEE_ASSERT(a_level_bound, clk_i, rst_ni, used <= PW'(DEPTH), "fifo level beyond depth")
  `BEE_ASSERT_NEVER(a_pop_empty, clk_i, rst_ni, req_i.pop && empty_o, "pop from empty fifo")
  `BEE_ASSERT_NEVER(a_push_full, clk_i, rst_ni, req_i.push && full_o, "push into full fifo")

endmodule

@@ src/button_event_engine.sv @@
`timescale 1ns / 1ps
`include "button_event_engine_macros.svh"

// Button event engine: a tick transfer (tuser 0) carries raw pin levels of
// four buttons, which are debounced and then fed to LOGICAL_BUTTONS press
// machines (four single buttons, two combos) whose events go into an event
// FIFO, dropped when it is full; a read transfer (tuser 1) pops one event.
// Every input transfer returns exactly one result transfer. Press machine
// state lives in a synchronous RAM that is walked one machine per cycle,
// so a tick result follows a pass over all LOGICAL_BUTTONS machines; a read
// of a non-empty FIFO waits for the event RAM read, and a read of an empty
// FIFO is answered straight from the idle state. One item is processed at
// a time; the next is accepted once the result register is free or being
// taken.
module button_event_engine #(
  parameter int unsigned FIFO_DEPTH      = bee_pkg::DEF_FIFO_DEPTH,
  parameter int unsigned LOGICAL_BUTTONS = bee_pkg::DEF_LOGICAL_BUTTONS
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  // configuration writes
  input  logic                              cfg_we_i,
  input  logic [bee_pkg::CFG_IDX_W-1:0]     cfg_idx_i,
  input  logic [bee_pkg::CFG_DATA_W-1:0]    cfg_data_i,
  // input stream
  input  logic                              s_axis_tvalid,
  output logic                              s_axis_tready,
  input  logic [bee_pkg::IN_TDATA_W-1:0]    s_axis_tdata,  // [3:0] raw_levels
  input  logic                              s_axis_tuser,  // [0] kind
  // result stream
  output logic                              m_axis_tvalid,
  input  logic                              m_axis_tready,
  // [2:0] event_button, [5:3] event_code, [8:6] events_written,
  // [11:9] events_dropped, [16:12] fifo_level
  output logic [bee_pkg::OUT_TDATA_W-1:0]   m_axis_tdata,
  output logic                              m_axis_tuser   // [0] event_valid
);

  import bee_pkg::*;

  localparam int unsigned MW        = (LOGICAL_BUTTONS > 1) ? $clog2(LOGICAL_BUTTONS) : 1;
  localparam int unsigned FIFO_PW   = $clog2(FIFO_DEPTH) + 1;
  localparam logic [MW-1:0] LAST_MACH = MW'(LOGICAL_BUTTONS - 1);

  typedef enum logic [2:0] {
    ST_IDLE = 3'b001,
    ST_RUN  = 3'b010,
    ST_READ = 3'b100
  } seq_state_e;

  // Configuration registers
  logic [HW_BUTTONS-1:0] active_high_q;
  logic [FILTER_W-1:0]   filter_q;
  logic [TICK_W-1:0]     long_press_q;
  logic [TICK_W-1:0]     hold_q;
  logic [KEYS_W-1:0]     combo_one_q;
  logic [KEYS_W-1:0]     combo_two_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      active_high_q <= RST_ACTIVE_HIGH;
      filter_q      <= RST_FILTER;
      long_press_q  <= RST_LONG_PRESS;
      hold_q        <= RST_HOLD;
      combo_one_q   <= RST_COMBO_ONE;
      combo_two_q   <= RST_COMBO_TWO;
    end else if (cfg_we_i) begin
      unique case (cfg_reg_e'(cfg_idx_i))
        REG_ACTIVE_HIGH: active_high_q <= cfg_data_i[HW_BUTTONS-1:0];
        REG_FILTER:      filter_q      <= cfg_data_i[FILTER_W-1:0];
        REG_LONG_PRESS:  long_press_q  <= cfg_data_i[TICK_W-1:0];
        REG_HOLD:        hold_q        <= cfg_data_i[TICK_W-1:0];
        REG_COMBO_ONE:   combo_one_q   <= cfg_data_i[KEYS_W-1:0];
        REG_COMBO_TWO:   combo_two_q   <= cfg_data_i[KEYS_W-1:0];
        default: ;
      endcase
    end
  end

  seq_state_e               state_q, state_d;
  logic [MW-1:0]            m_q, m_d;
  logic [LOGICAL_BUTTONS-1:0] pvalid_q, pvalid_d;
  logic [CNT_W-1:0]         wr_cnt_q, wr_cnt_d, drop_cnt_q, drop_cnt_d;

  logic                     out_valid_q, out_valid_d;
  logic                     out_ev_valid_q, out_ev_valid_d;
  logic [2:0]               out_btn_q, out_btn_d;
  logic [2:0]               out_code_q, out_code_d;
  logic [CNT_W-1:0]         out_wr_q, out_wr_d;
  logic [CNT_W-1:0]         out_drop_q, out_drop_d;
  logic [LEVEL_W-1:0]       out_level_q, out_level_d;

  logic                     in_fire;
  logic                     tick_fire;
  logic [HW_BUTTONS-1:0]    deb;

  logic                     press_re, press_we;
  logic [MW-1:0]            press_raddr;
  logic [PRESS_ENTRY_W-1:0] press_rdata;
  press_entry_t             cur_entry;
  press_res_t               press_res;

  fifo_req_t                fifo_req;
  logic [EVENT_W-1:0]       fifo_rdata;
  logic                     fifo_empty, fifo_full;
  logic [FIFO_PW-1:0]       fifo_level;

  assign s_axis_tready = (state_q == ST_IDLE) && (!out_valid_q || m_axis_tready);
  assign in_fire       = s_axis_tvalid && s_axis_tready;
  assign tick_fire     = in_fire && (kind_e'(s_axis_tuser) == KIND_TICK);

  bee_debounce u_debounce (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .tick_i        (tick_fire),
    .raw_i         (s_axis_tdata[HW_BUTTONS-1:0]),
    .active_high_i (active_high_q),
    .filter_i      (filter_q),
    .deb_o         (deb)
  );

  // Press state memory; an entry never written reads as idle
  bee_ram #(
    .WIDTH (PRESS_ENTRY_W),
    .DEPTH (LOGICAL_BUTTONS),
    .AW    (MW)
  ) u_press_mem (
    .clk_i   (clk_i),
    .we_i    (press_we),
    .waddr_i (m_q),
    .wdata_i (press_res.entry),
    .re_i    (press_re),
    .raddr_i (press_raddr),
    .rdata_o (press_rdata)
  );

  assign cur_entry = pvalid_q[m_q] ? press_entry_t'(press_rdata) : PRESS_RESET;

  bee_press_step u_step (
    .entry_i      (cur_entry),
    .mach_i       (MACH_W'(m_q)),
    .deb_i        (deb),
    .combo_one_i  (combo_one_q),
    .combo_two_i  (combo_two_q),
    .long_press_i (long_press_q),
    .hold_i       (hold_q),
    .res_o        (press_res)
  );

  bee_event_fifo #(
    .DEPTH (FIFO_DEPTH)
  ) u_fifo (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .req_i     (fifo_req),
    .rd_data_o (fifo_rdata),
    .empty_o   (fifo_empty),
    .full_o    (fifo_full),
    .level_o   (fifo_level)
  );

  // Sequencer: one press machine per cycle, reading the next entry while
  // writing back the current one
  always_comb begin
    logic push_ok;
    push_ok        = 1'b0;
    state_d        = state_q;
    m_d            = m_q;
    pvalid_d       = pvalid_q;
    wr_cnt_d       = wr_cnt_q;
    drop_cnt_d     = drop_cnt_q;
    press_re       = 1'b0;
    press_we       = 1'b0;
    press_raddr    = '0;
    fifo_req       = '0;
    out_valid_d    = out_valid_q && !m_axis_tready;
    out_ev_valid_d = out_ev_valid_q;
    out_btn_d      = out_btn_q;
    out_code_d     = out_code_q;
    out_wr_d       = out_wr_q;
    out_drop_d     = out_drop_q;
    out_level_d    = out_level_q;
    unique case (state_q)
      ST_IDLE: begin
        if (in_fire) begin
          if (kind_e'(s_axis_tuser) == KIND_TICK) begin
            press_re   = 1'b1;
            m_d        = '0;
            wr_cnt_d   = '0;
            drop_cnt_d = '0;
            state_d    = ST_RUN;
          end else if (!fifo_empty) begin
            fifo_req.pop = 1'b1;
            state_d      = ST_READ;
          end else begin
            out_valid_d    = 1'b1;
            out_ev_valid_d = 1'b0;
            out_btn_d      = '0;
            out_code_d     = '0;
            out_wr_d       = '0;
            out_drop_d     = '0;
            out_level_d    = LEVEL_W'(fifo_level);
          end
        end
      end
      ST_RUN: begin
        press_we      = 1'b1;
        pvalid_d[m_q] = 1'b1;
        if (press_res.push) begin
          if (fifo_full) begin
            drop_cnt_d = drop_cnt_q + CNT_W'(1);
          end else begin
            push_ok       = 1'b1;
            fifo_req.push = 1'b1;
            fifo_req.data = {3'(m_q), press_res.code};
            wr_cnt_d      = wr_cnt_q + CNT_W'(1);
          end
        end
        if (m_q == LAST_MACH) begin
          out_valid_d    = 1'b1;
          out_ev_valid_d = 1'b0;
          out_btn_d      = '0;
          out_code_d     = '0;
          out_wr_d       = wr_cnt_d;
          out_drop_d     = drop_cnt_d;
          out_level_d    = LEVEL_W'(fifo_level + FIFO_PW'(push_ok));
          state_d        = ST_IDLE;
        end else begin
          m_d         = m_q + MW'(1);
          press_re    = 1'b1;
          press_raddr = m_q + MW'(1);
        end
      end
      ST_READ: begin
        out_valid_d    = 1'b1;
        out_ev_valid_d = 1'b1;
        out_btn_d      = fifo_rdata[5:3];
        out_code_d     = fifo_rdata[2:0];
        out_wr_d       = '0;
        out_drop_d     = '0;
        out_level_d    = LEVEL_W'(fifo_level);
        state_d        = ST_IDLE;
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      m_q         <= '0;
      pvalid_q    <= '0;
      wr_cnt_q    <= '0;
      drop_cnt_q  <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      m_q         <= m_d;
      pvalid_q    <= pvalid_d;
      wr_cnt_q    <= wr_cnt_d;
      drop_cnt_q  <= drop_cnt_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Result payload
  always_ff @(posedge clk_i) begin
    out_ev_valid_q <= out_ev_valid_d;
    out_btn_q      <= out_btn_d;
    out_code_q     <= out_code_d;
    out_wr_q       <= out_wr_d;
    out_drop_q     <= out_drop_d;
    out_level_q    <= out_level_d;
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tuser  = out_ev_valid_q;
  assign m_axis_tdata  = {7'b0, out_level_q, out_drop_q, out_wr_q, out_code_q, out_btn_q};

  `BEE_ASSERT(a_run_index, clk_i, rst_ni, (state_q == ST_RUN) |-> (m_q <= LAST_MACH), "machine index out of range")
  `BEE_ASSERT(a_read_result, clk_i, rst_ni, (state_q == ST_READ) |=> (out_valid_q && out_ev_valid_q), "read did not return an event")
  `BEE_ASSERT(a_tick_result, clk_i, rst_ni, (state_q == ST_RUN && m_q == LAST_MACH) |=> (out_valid_q && !out_ev_valid_q), "tick did not return a result")

endmodule
